/* hdl/ilse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilse_pkg: shared types and constants of the indexed list shift engine
// Item structs, opcode and status codes, list sizing and cell control.
// ----------------------------------------------------------------------------
package ilse_pkg;

  localparam int Capacity = 16;
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int PosW     = 4;
  localparam int CmpW     = (CntW > PosW) ? CntW : PosW;
  localparam int DataW    = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_SEARCH = 3'd2,
    OP_APPEND = 3'd3,
    OP_MODIFY = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]              opcode;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic       found;
    logic [3:0] found_position;
    logic [4:0] entry_count;
  } out_item_t;

  // broadcast to every cell
  typedef struct packed {
    logic                    upd;
    logic [2:0]              opcode;
    logic [CmpW-1:0]         pos;
    logic [CmpW-1:0]         cnt;
    logic signed [DataW-1:0] value;
  } cell_ctl_t;

endpackage

/* hdl/ilse_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilse_cell: one list entry
// Holds one value, shifts from its neighbors on insert or delete, takes the
// request value on a write to its place, and compares for search.
// ----------------------------------------------------------------------------
module ilse_cell
  import ilse_pkg::*;
(
  input  logic                    clk_i,
  input  logic [CmpW-1:0]         idx_i,
  input  cell_ctl_t               ctl_i,
  input  logic signed [DataW-1:0] lower_i,
  input  logic signed [DataW-1:0] upper_i,
  input  logic                    hit_i,
  input  logic [CmpW-1:0]         hit_pos_i,
  output logic signed [DataW-1:0] data_o,
  output logic                    hit_o,
  output logic [CmpW-1:0]         hit_pos_o
);

  logic signed [DataW-1:0] data_q, data_d;
  logic                    match;

  always_comb begin
    data_d = data_q;
    if (ctl_i.upd) begin
      case (ctl_i.opcode)
        OP_INSERT: begin
          if (idx_i == ctl_i.pos) begin
            data_d = ctl_i.value;
          end else if (idx_i > ctl_i.pos) begin
            data_d = lower_i;
          end
        end
        OP_DELETE: begin
          if (idx_i >= ctl_i.pos) begin
            data_d = upper_i;
          end
        end
        OP_APPEND: begin
          if (idx_i == ctl_i.cnt) begin
            data_d = ctl_i.value;
          end
        end
        OP_MODIFY: begin
          if (idx_i == ctl_i.pos) begin
            data_d = ctl_i.value;
          end
        end
        default: data_d = data_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign match     = (idx_i < ctl_i.cnt) && (data_q == ctl_i.value);
  assign hit_o     = hit_i | match;
  assign hit_pos_o = hit_i ? hit_pos_i : (match ? idx_i : '0);
  assign data_o    = data_q;

endmodule

/* hdl/indexed_list_shift_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_shift_engine_unit: bounded ordered list with indexed access
// Insert, delete, append, modify and search on a list of signed 32-bit
// values held in a row of cells.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the output stalls, and returns its result in the next
// cycle from an output register; input ready stays high while that register is empty or
// being taken. Each of the Capacity cells holds one entry and reads its two
// neighbors, so insert and delete shift the whole list at once, and a
// search ripples a hit flag and position through the cell row in the same
// cycle. No clearing pass is needed after reset.
module indexed_list_shift_engine_unit
  import ilse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic                    out_valid_q;
  out_item_t               result_q, result_d;
  logic [CntW-1:0]         count_q, count_d;
  logic                    accept;
  logic                    ok;
  status_e                 status;
  logic [CmpW-1:0]         pos_ext, cnt_ext;
  cell_ctl_t               ctl;

  logic signed [DataW-1:0] data   [Capacity];
  logic                    hit    [Capacity+1];
  logic [CmpW-1:0]         hitpos [Capacity+1];

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = result_q;

  assign pos_ext = CmpW'(in_item_i.position);
  assign cnt_ext = CmpW'(count_q);

  always_comb begin
    status  = ST_OK;
    count_d = count_q;
    case (in_item_i.opcode)
      OP_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status = ST_BADPOS;
        end else if (cnt_ext >= CmpW'(Capacity)) begin
          status = ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      OP_DELETE: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status = ST_BADPOS;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      OP_APPEND: begin
        if (cnt_ext >= CmpW'(Capacity)) begin
          status = ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      OP_MODIFY: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status = ST_BADPOS;
        end
      end
      default: status = ST_OK;
    endcase
  end

  assign ok = (status == ST_OK);

  assign ctl.upd    = accept && ok;
  assign ctl.opcode = in_item_i.opcode;
  assign ctl.pos    = pos_ext;
  assign ctl.cnt    = cnt_ext;
  assign ctl.value  = in_item_i.value;

  assign hit[0]    = 1'b0;
  assign hitpos[0] = '0;

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic signed [DataW-1:0] lower, upper;
    if (g == 0) begin : g_first
      assign lower = in_item_i.value;
    end else begin : g_mid_lo
      assign lower = data[g-1];
    end
    if (g == Capacity - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = data[g+1];
    end
    ilse_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (CmpW'(g)),
      .ctl_i     (ctl),
      .lower_i   (lower),
      .upper_i   (upper),
      .hit_i     (hit[g]),
      .hit_pos_i (hitpos[g]),
      .data_o    (data[g]),
      .hit_o     (hit[g+1]),
      .hit_pos_o (hitpos[g+1])
    );
  end

  always_comb begin
    result_d                = '0;
    result_d.status         = status;
    result_d.entry_count    = 5'(count_d);
    if (in_item_i.opcode == OP_SEARCH) begin
      result_d.found          = hit[Capacity];
      result_d.found_position = hitpos[Capacity][3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

endmodule

/* sim/tb_indexed_list_shift_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_shift_engine_unit: self-checking bench for the list engine
// Drives insert, delete, search, append, modify and unused opcodes through a
// valid/ready port with random gaps and stalls on both sides. It keeps its
// own copy of the list to predict each result, and compares every field of
// each returned item in order.
// ----------------------------------------------------------------------------
module tb_indexed_list_shift_engine_unit;
  import ilse_pkg::*;

  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam int NumRandom  = 600;
  localparam int CycleLimit = 400000;
  localparam int MaxReports = 10;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  indexed_list_shift_engine_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // list copy used for prediction
  logic signed [DataW-1:0] list_vals [Capacity];
  int                      list_len = 0;

  in_item_t  request_queue[$];
  out_item_t pending_results[$];

  // generator side: list length as the requests will leave it
  int                      gen_len = 0;
  logic signed [DataW-1:0] val_pool [8];

  int cycle_cnt    = 0;
  int accepted_cnt = 0;
  int err_cnt      = 0;
  int tx_gap       = 0;
  int rx_gap       = 0;
  bit in_taken     = 1'b0;
  bit rx_hold      = 1'b0;

  function automatic out_item_t list_predict(in_item_t req);
    out_item_t res;
    int        p;
    int        i;
    res = '0;
    res.status = ST_OK;
    p = int'(req.position);
    case (req.opcode)
      OP_INSERT: begin
        if (p > list_len) res.status = ST_BADPOS;
        else if (list_len >= Capacity) res.status = ST_FULL;
        else begin
          for (i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
          list_vals[p] = req.value;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else if (p >= list_len) res.status = ST_BADPOS;
        else begin
          for (i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      OP_SEARCH: begin
        for (i = 0; i < list_len && !res.found; i++) begin
          if (list_vals[i] == req.value) begin
            res.found          = 1'b1;
            res.found_position = 4'(i);
          end
        end
      end
      OP_APPEND: begin
        if (list_len >= Capacity) res.status = ST_FULL;
        else begin
          list_vals[list_len] = req.value;
          list_len++;
        end
      end
      OP_MODIFY: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else if (p >= list_len) res.status = ST_BADPOS;
        else list_vals[p] = req.value;
      end
      default: ;
    endcase
    res.entry_count = 5'(list_len);
    return res;
  endfunction

  function automatic void track_len(in_item_t req);
    int p;
    p = int'(req.position);
    case (req.opcode)
      OP_INSERT: if (p <= gen_len && gen_len < Capacity) gen_len++;
      OP_DELETE: if (gen_len != 0 && p < gen_len) gen_len--;
      OP_APPEND: if (gen_len < Capacity) gen_len++;
      default: ;
    endcase
  endfunction

  function automatic void add_request(logic [2:0] op, int pos, logic signed [DataW-1:0] val);
    in_item_t req;
    req.opcode   = op;
    req.position = 4'(pos);
    req.value    = val;
    request_queue.push_back(req);
    track_len(req);
  endfunction

  // mode 0 fills, 1 drains, 2 mixes
  function automatic void add_random_request(int mode);
    logic [2:0]              op;
    int                      r;
    int                      pos;
    logic signed [DataW-1:0] val;
    r = $urandom_range(0, 99);
    case (mode)
      0: op = (r < 35) ? OP_INSERT : (r < 65) ? OP_APPEND : (r < 80) ? OP_SEARCH :
              (r < 90) ? OP_MODIFY : (r < 96) ? OP_DELETE : 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
      1: op = (r < 50) ? OP_DELETE : (r < 60) ? OP_INSERT : (r < 65) ? OP_APPEND :
              (r < 80) ? OP_SEARCH : (r < 96) ? OP_MODIFY : 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
      default: op = (r < 20) ? OP_INSERT : (r < 40) ? OP_DELETE : (r < 60) ? OP_SEARCH :
                    (r < 76) ? OP_APPEND : (r < 96) ? OP_MODIFY :
                    3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
    endcase
    if ($urandom_range(0, 4) == 0) pos = $urandom_range(0, 15);
    else if (op == OP_INSERT) pos = $urandom_range(0, (gen_len > 15) ? 15 : gen_len);
    else if (op == OP_DELETE || op == OP_MODIFY) pos = (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0;
    else pos = $urandom_range(0, 15);
    if ($urandom_range(0, 19) == 0) val_pool[$urandom_range(0, 7)] = $urandom;
    val = ($urandom_range(0, 3) == 0) ? DataW'($urandom) : val_pool[$urandom_range(0, 7)];
    add_request(op, pos, val);
  endfunction

  // mostly short gaps, a few long, none inside a periodic quiet window
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if ((cycle_cnt / 128) % 8 == 0) return 0;
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk_i) begin : request_drive
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      in_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (request_queue.size() > 0) begin
        in_item_i  <= request_queue.pop_front();
        in_valid_i <= 1'b1;
        tx_gap = idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : result_ready_drive
    if (rx_hold) begin
      out_ready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      rx_gap = idle_len();
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pending_results.push_back(list_predict(in_item_i));
        accepted_cnt++;
        in_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          if (err_cnt < MaxReports)
            $display("unexpected result: status %0d found %0d pos %0d count %0d",
                     out_item_o.status, out_item_o.found, out_item_o.found_position,
                     out_item_o.entry_count);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (out_item_o.status !== want.status || out_item_o.found !== want.found ||
              out_item_o.found_position !== want.found_position ||
              out_item_o.entry_count !== want.entry_count) begin
            if (err_cnt < MaxReports)
              $display("mismatch: exp status %0d found %0d pos %0d count %0d, got status %0d found %0d pos %0d count %0d",
                       want.status, want.found, want.found_position, want.entry_count,
                       out_item_o.status, out_item_o.found, out_item_o.found_position,
                       out_item_o.entry_count);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_indexed_list_shift_engine_unit NOT OK");
      $finish;
    end
  end

  // long output stall so the result register fills and input backs up
  initial begin : output_hold
    while (accepted_cnt < 150) @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (200) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin : stimulus
    int mode;
    mode = 0;
    val_pool[0] = 32'sh8000_0000;
    val_pool[1] = 32'sh7fff_ffff;
    val_pool[2] = '0;
    val_pool[3] = -32'sd1;
    for (int k = 4; k < 8; k++) val_pool[k] = $urandom;

    add_request(OP_SEARCH, 0, 0);
    add_request(OP_DELETE, 0, 0);
    add_request(OP_MODIFY, 0, 1);
    add_request(OP_INSERT, 1, 2);
    add_request(OP_INSERT, 0, 32'sh8000_0000);
    add_request(OP_APPEND, 15, 32'sh7fff_ffff);
    add_request(OP_INSERT, 1, -32'sd1);
    add_request(OP_SEARCH, 15, -32'sd1);
    add_request(OP_SEARCH, 0, 5);
    add_request(OP_MODIFY, 2, 0);
    add_request(OP_MODIFY, 3, 7);
    add_request(OP_DELETE, 3, 0);
    add_request(OP_DELETE, 0, 0);
    for (int k = OP_RSVD_LO; k <= OP_RSVD_HI; k++) add_request(3'(k), 15, $urandom);
    repeat (13) add_request(OP_APPEND, 0, $urandom);
    add_request(OP_APPEND, 0, 0);
    add_request(OP_INSERT, 0, 9);
    add_request(OP_APPEND, 0, 9);
    add_request(OP_SEARCH, 0, 0);
    add_request(OP_DELETE, 15, 0);
    add_request(OP_MODIFY, 15, 3);
    add_request(OP_INSERT, 15, 32'sh7fff_ffff);

    for (int n = 0; n < NumRandom; n++) begin
      if (n % 60 == 0) mode = $urandom_range(0, 2);
      add_random_request(mode);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_indexed_list_shift_engine_unit OK");
    end else begin
      $display("tb_indexed_list_shift_engine_unit NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/ilse_pkg.sv
hdl/ilse_cell.sv
hdl/indexed_list_shift_engine_unit.sv
sim/tb_indexed_list_shift_engine_unit.sv
